[hw/rtl/wmsba_pkg.sv]
// ============================================================================
// wmsba_pkg: shared types and constants for the weighted mean-square block
// accumulator (sub-block loudness power).
// ============================================================================
package wmsba_pkg;

    // result field and its byte-padded stream width
    localparam int OUT_W       = 53;
    localparam int OUT_TDATA_W = 56;

    // register widths
    localparam int LEN_W    = 16;
    localparam int WEIGHT_W = 16;

    // width of one operand of the shared multiplier
    localparam int MUL_W = 32;

    // weights are Q4.12
    localparam int FRAC_BITS = 12;

    // register indexes
    localparam int REG_LEN     = 0;
    localparam int REG_WEIGHT0 = 1;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd4800;
    localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};

    // reset weights for up to eight channels
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [8] = '{
        16'd4096, 16'd4096, 16'd4096, 16'd0,
        16'd5775, 16'd5775, 16'd4096, 16'd4096
    };

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACC   = 6'b000010,
        ST_WEIGH = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

endpackage

[hw/rtl/weighted_mean_square_block_accumulator.sv]
// ============================================================================
// weighted_mean_square_block_accumulator
// Sums squared samples per channel over a sub-block of frames, then emits
// floor(sum_c weight_c * squares_c / (4096 * length)), saturated to 53 bits.
// ============================================================================
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  one frame, a sample per channel
// m_axis    out        m_axis_tvalid / m_axis_tready  block_power
// cfg       in         i_cfg_we                       i_cfg_idx, i_cfg_data
//
// A frame that does not close a sub-block is squared channel by channel (one
// squaring pass of the shared 32x32 multiplier per channel).
// A closing frame then multiply-accumulates two 32-bit limbs per channel,
// loads the divider and runs the bit-serial divider for DIV_W quotient bits
// (69 for six 24-bit channels), then loads the output register.
// Reset is synchronous, active low; it clears sums, count and weights to
// their defaults. The output register holds a word until it is taken; a
// closing frame waits in the last step only if that word is still pending.
module weighted_mean_square_block_accumulator #(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 24,
    localparam int IN_TDATA_W = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_IDX_W  = $clog2(CHANNELS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample_ch0 .. sample_chN-1, SAMPLE_BITS each, zero padded to bytes
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [IN_TDATA_W-1:0]                s_axis_tdata,
    // block_power [52:0], zero padded to 56 bits
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [wmsba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // register write port
    input  logic                                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [wmsba_pkg::WEIGHT_W-1:0]       i_cfg_data
);
    import wmsba_pkg::*;

    localparam int FRAME_W = CHANNELS * SAMPLE_BITS;
    localparam int SUM_W   = 2 * SAMPLE_BITS + 14;
    localparam int ACC_W   = SUM_W + WEIGHT_W + 3;
    localparam int DIV_W   = ACC_W - FRAC_BITS;
    localparam int CMP_W   = (DIV_W > OUT_W) ? DIV_W : OUT_W;
    localparam int STEP_W  = $clog2(DIV_W);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state                  r_state, n_state;
    logic [STEP_W-1:0]       r_step;
    logic [LEN_W-1:0]        r_count;
    logic [LEN_W-1:0]        r_len;
    logic [WEIGHT_W-1:0]     r_weight [CHANNELS];
    logic [SUM_W-1:0]        r_sum [CHANNELS];
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic [FRAME_W-1:0]      r_frame;
    logic [ACC_W-1:0]        r_acc;
    logic [DIV_W-1:0]        r_quo;
    logic [LEN_W-1:0]        r_rem;

    logic [LEN_W-1:0]        len_eff;
    logic [CH_W-1:0]         acc_ch;
    logic [CH_W-1:0]         wgt_ch;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [2*MUL_W-1:0]      sum_ext;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      prod;
    logic [ACC_W-1:0]        addend;
    logic [LEN_W:0]          trial;
    logic [LEN_W:0]          diff;
    logic                    q_bit;
    logic                    sat;
    logic                    step_last;
    logic                    out_free;

    // effective sub-block length: zero acts as one
    assign len_eff = (r_len == '0) ? LEN_W'(1) : r_len;

    assign acc_ch = r_step[CH_W-1:0];
    assign wgt_ch = r_step[CH_W:1];

    // magnitude of the current sample
    assign sample = r_frame[SAMPLE_BITS-1:0];
    assign mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    // shared multiplier: square in ACC, weight times limb in WEIGH
    assign sum_ext = (2*MUL_W)'(r_sum[wgt_ch]);
    always_comb begin
        if (r_state == ST_WEIGH) begin
            mul_a = MUL_W'(r_weight[wgt_ch]);
            mul_b = r_step[0] ? sum_ext[2*MUL_W-1:MUL_W] : sum_ext[MUL_W-1:0];
        end else begin
            mul_a = MUL_W'(mag);
            mul_b = MUL_W'(mag);
        end
    end
    assign prod   = mul_a * mul_b;
    assign addend = r_step[0] ? (ACC_W'(prod) << MUL_W) : ACC_W'(prod);

    // one restoring division step
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, len_eff};
    assign q_bit = (trial >= {1'b0, len_eff});

    assign sat      = (CMP_W'(r_quo) > CMP_W'(OUT_MAX));
    assign out_free = !r_out_valid || m_axis_tready;

    // last step of the current phase
    always_comb begin
        case (r_state)
            ST_ACC:   step_last = (r_step == STEP_W'(CHANNELS - 1));
            ST_WEIGH: step_last = (r_step == STEP_W'(2 * CHANNELS - 1));
            ST_DIV:   step_last = (r_step == STEP_W'(DIV_W - 1));
            default:  step_last = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_ACC;
            ST_ACC: begin
                if (step_last) n_state = (r_count >= len_eff) ? ST_WEIGH : ST_IDLE;
            end
            ST_WEIGH: if (step_last) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (step_last) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_len       <= LEN_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_weight[c] <= WEIGHT_RESET[c];
                r_sum[c]    <= '0;
            end
        end else begin
            r_state <= n_state;

            // advance the step counter, restart it on each phase change
            if (n_state != r_state) r_step <= '0;
            else                    r_step <= r_step + 1'b1;

            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_LEN)) r_len <= i_cfg_data;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (i_cfg_idx == CFG_IDX_W'(REG_WEIGHT0 + c)) r_weight[c] <= i_cfg_data;
                end
            end

            // count the accepted frame
            if (s_axis_tvalid && s_axis_tready) r_count <= r_count + 1'b1;

            // add one channel's square
            if (r_state == ST_ACC) r_sum[acc_ch] <= r_sum[acc_ch] + SUM_W'(prod);

            // drop the sums once they are weighed
            if (r_state == ST_LOAD) begin
                r_count <= '0;
                for (int c = 0; c < CHANNELS; c++) r_sum[c] <= '0;
            end

            // output register
            if (r_state == ST_OUT && out_free)      r_out_valid <= 1'b1;
            else if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // hold the frame, shift one sample out per channel step
        if (s_axis_tvalid && s_axis_tready) r_frame <= s_axis_tdata[FRAME_W-1:0];
        else if (r_state == ST_ACC)         r_frame <= r_frame >> SAMPLE_BITS;

        if (r_state == ST_ACC)   r_acc <= '0;
        if (r_state == ST_WEIGH) r_acc <= r_acc + addend;

        // drop the Q4.12 fraction and start the division
        if (r_state == ST_LOAD) begin
            r_quo <= r_acc[ACC_W-1:FRAC_BITS];
            r_rem <= '0;
        end
        if (r_state == ST_DIV) begin
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
            r_rem <= q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end

        if (r_state == ST_OUT && out_free) r_out_data <= sat ? OUT_MAX : OUT_W'(r_quo);
    end

`ifndef SYNTHESIS
    // the remainder stays below the divisor throughout the division
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < len_eff))
        else $error("division remainder not below length");

    // closing a sub-block clears the frame count and the sums
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_count == '0 && r_sum[0] == '0))
        else $error("sub-block state not cleared");

    // a new result word appears only from the output step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result word raised outside output step");

    // the input side stays closed while a frame is in work
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC || r_state == ST_WEIGH || r_state == ST_DIV) |-> !s_axis_tready)
        else $error("input open while busy");
`endif

endmodule
